// ----- sv/fale_pkg.sv -----
// Shared codes and types for the fixed-capacity list engine.
`timescale 1ns / 1ps

package fale_pkg;

	localparam logic [2:0] ACT_PUSH_TAIL = 3'd0;
	localparam logic [2:0] ACT_PUSH_HEAD = 3'd1;
	localparam logic [2:0] ACT_POP_TAIL  = 3'd2;
	localparam logic [2:0] ACT_POP_HEAD  = 3'd3;
	localparam logic [2:0] ACT_ERASE     = 3'd4;
	localparam logic [2:0] ACT_FIND      = 3'd5;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_FULL     = 3'd1;
	localparam logic [2:0] ST_EMPTY    = 3'd2;
	localparam logic [2:0] ST_BADPOS   = 3'd3;
	localparam logic [2:0] ST_NOTFOUND = 3'd4;

	// match bits examined per scan cycle
	localparam int SCAN_GROUP = 16;

	// command broadcast to every cell of the chain
	typedef struct packed {
		logic              push_tail;
		logic              push_head;
		logic              shift_down;
		logic              cmp;
		logic signed [31:0] data;
		logic [6:0]        pos;
	} cell_ctl_t;

	typedef struct packed {
		logic done;
		logic hit;
	} scan_res_t;

endpackage

// ----- sv/fixed_array_list_engine_core.sv -----
// Top level of the fixed-capacity list engine: request decode, cell row, find scan.
`timescale 1ns / 1ps

// Fixed-capacity ordered list of signed 32-bit words held in a row of cells, one
// entry per cell. Push tail, push head, pop tail, pop head and erase update the
// cells in parallel (push head shifts all entries up, pop head and erase shift
// entries from the position down, push tail writes the slot after the last, pop
// tail only lowers the count); the result is registered at the same edge that
// accepts the request. Find: every cell compares its entry at the accepting edge,
// the match bits are then loaded into the scanner, and the scanner checks 16
// match bits per cycle and stops at the first hit. Requests are taken one at a
// time; a new request is accepted while a finished result waits in the output
// register only if that register is being drained in the same cycle. Rejected
// operations (full, empty, bad position) leave the list untouched and report a status code.
module fixed_array_list_engine_core
	import fale_pkg::*;
#(
	parameter int CAPACITY = 128
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         action,
	input  logic signed [31:0] data,
	input  logic [6:0]         position,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         status,
	output logic [6:0]         found_index,
	output logic [7:0]         count
);

	localparam int IDXW = $clog2(CAPACITY);
	localparam int CNTW = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOAD,
		S_SCAN
	} state_t;

	state_t               state_q;
	logic [CNTW-1:0]      cnt_q;
	logic [CNTW-1:0]      next_cnt;
	logic [2:0]           st_next;
	logic                 out_valid_q;
	logic [2:0]           status_q;
	logic [6:0]           found_q;
	logic [7:0]           count_q;
	logic                 in_acc;
	logic                 out_free;
	logic                 is_find;
	logic                 full;
	logic                 empty;
	cell_ctl_t            ctl;
	scan_res_t            scan_res;
	logic [IDXW-1:0]      scan_idx;
	logic                 scan_ack;
	logic signed [31:0]   vals [CAPACITY];
	logic [CAPACITY-1:0]  match;
	logic [CNTW+7:0]      cnt_ext;
	logic [IDXW+6:0]      idx_ext;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE) || !out_free;
	assign in_acc   = in_valid && !in_stall;
	assign is_find  = (action == ACT_FIND);
	assign full     = (cnt_q == CNTW'(CAPACITY));
	assign empty    = (cnt_q == '0);
	assign scan_ack = (state_q == S_SCAN) && scan_res.done && out_free;

	// request decode
	always_comb begin
		next_cnt       = cnt_q;
		st_next        = ST_OK;
		ctl            = '0;
		ctl.data       = data;
		ctl.pos        = position;
		if (in_acc) begin
			unique case (action)
				ACT_PUSH_TAIL, ACT_PUSH_HEAD: begin
					if (full) begin
						st_next = ST_FULL;
					end else begin
						ctl.push_tail = (action == ACT_PUSH_TAIL);
						ctl.push_head = (action == ACT_PUSH_HEAD);
						next_cnt      = CNTW'(cnt_q + 1'b1);
					end
				end
				ACT_POP_TAIL: begin
					if (empty) st_next = ST_EMPTY;
					else next_cnt = CNTW'(cnt_q - 1'b1);
				end
				ACT_POP_HEAD: begin
					if (empty) begin
						st_next = ST_EMPTY;
					end else begin
						ctl.shift_down = 1'b1;
						ctl.pos        = '0;
						next_cnt       = CNTW'(cnt_q - 1'b1);
					end
				end
				ACT_ERASE: begin
					if (empty) begin
						st_next = ST_EMPTY;
					end else if (32'(position) >= 32'(cnt_q)) begin
						st_next = ST_BADPOS;
					end else begin
						ctl.shift_down = 1'b1;
						next_cnt       = CNTW'(cnt_q - 1'b1);
					end
				end
				ACT_FIND: begin
					ctl.cmp = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			logic signed [31:0] left_v;
			logic signed [31:0] right_v;
			if (gi == 0) begin : g_first
				assign left_v = '0;
			end else begin : g_mid_l
				assign left_v = vals[gi-1];
			end
			if (gi == CAPACITY - 1) begin : g_last
				assign right_v = vals[gi];
			end else begin : g_mid_r
				assign right_v = vals[gi+1];
			end
			fale_cell #(
				.IDX  (gi),
				.CNTW (CNTW)
			) u_cell (
				.clk   (clk),
				.ctl   (ctl),
				.count (cnt_q),
				.left  (left_v),
				.right (right_v),
				.value (vals[gi]),
				.match (match[gi])
			);
		end
	endgenerate

	fale_scan #(
		.CAPACITY (CAPACITY)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_LOAD),
		.ack    (scan_ack),
		.match  (match),
		.res    (scan_res),
		.idx    (scan_idx)
	);

	assign cnt_ext = {8'b0, next_cnt};
	assign idx_ext = {7'b0, scan_idx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			cnt_q <= next_cnt;
			// a new result may load in the same cycle the old one drains
			if ((in_acc && !is_find) || scan_ack) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc && is_find) begin
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (scan_ack) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (in_acc && !is_find) begin
			status_q <= st_next;
			found_q  <= '0;
			count_q  <= cnt_ext[7:0];
		end else if (scan_ack) begin
			status_q <= scan_res.hit ? ST_OK : ST_NOTFOUND;
			found_q  <= scan_res.hit ? idx_ext[6:0] : 7'd0;
			count_q  <= cnt_ext[7:0];
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign found_index = found_q;
	assign count       = count_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNTW'(CAPACITY))
		else $error("entry count above capacity");

	a_cnt_only_on_request: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != $past(cnt_q)) |-> $past(in_acc))
		else $error("count changed without an accepted request");

	a_find_enters_load: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && is_find) |=> (state_q == S_LOAD))
		else $error("find request did not start the compare sequence");

	a_scan_done_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		scan_res.done |-> (state_q == S_SCAN))
		else $error("scanner finished outside the scan phase");

endmodule

// ----- sv/fale_cell.sv -----
// One list slot: holds an entry, moves it to or from its neighbors, compares it.
`timescale 1ns / 1ps

module fale_cell
	import fale_pkg::*;
#(
	parameter int IDX  = 0,
	parameter int CNTW = 8
) (
	input  logic               clk,
	input  cell_ctl_t          ctl,
	input  logic [CNTW-1:0]    count,
	input  logic signed [31:0] left,
	input  logic signed [31:0] right,
	output logic signed [31:0] value,
	output logic               match
);

	logic signed [31:0] value_q;
	logic               match_q;

	always_ff @(posedge clk) begin
		if (ctl.push_head) begin
			value_q <= (IDX == 0) ? ctl.data : left;
		end else if (ctl.push_tail && (count == CNTW'(IDX))) begin
			value_q <= ctl.data;
		end else if (ctl.shift_down && (32'(ctl.pos) <= 32'(IDX))) begin
			value_q <= right;
		end
		if (ctl.cmp) begin
			match_q <= (value_q == ctl.data) && (CNTW'(IDX) < count);
		end
	end

	assign value = value_q;
	assign match = match_q;

endmodule

// ----- sv/fale_scan.sv -----
// Lowest-set-bit search over the cell match bits, one group per cycle.
`timescale 1ns / 1ps

module fale_scan
	import fale_pkg::*;
#(
	parameter int CAPACITY = 128
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         ack,
	input  logic [CAPACITY-1:0]          match,
	output scan_res_t                    res,
	output logic [$clog2(CAPACITY)-1:0]  idx
);

	localparam int IDXW = $clog2(CAPACITY);
	localparam int G    = (CAPACITY < SCAN_GROUP) ? CAPACITY : SCAN_GROUP;
	localparam int NG   = (CAPACITY + G - 1) / G;
	localparam int GW   = (NG > 1) ? $clog2(NG) : 1;

	logic [NG*G-1:0] vec_q;
	logic [GW-1:0]   grp_q;
	logic            busy_q;
	logic [G-1:0]    low;
	logic [IDXW-1:0] enc;
	logic            last;

	assign low  = vec_q[G-1:0];
	assign last = (grp_q == GW'(NG - 1));

	always_comb begin
		enc = '0;
		for (int k = G - 1; k >= 0; k--) begin
			if (low[k]) enc = IDXW'(k);
		end
	end

	assign res.hit  = |low;
	assign res.done = busy_q && ((|low) || last);
	assign idx      = IDXW'(32'(grp_q) * G + 32'(enc));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			grp_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			grp_q  <= '0;
		end else if (res.done) begin
			if (ack) busy_q <= 1'b0;
		end else if (busy_q) begin
			grp_q <= GW'(grp_q + 1'b1);
		end
	end

	// match bits slide down the row so the low group is always the one checked
	always_ff @(posedge clk) begin
		if (start) begin
			vec_q <= (NG*G)'(match);
		end else if (busy_q && !res.done) begin
			vec_q <= vec_q >> G;
		end
	end

endmodule
